// ===== sv/mce_pkg.sv =====
// media clock extrapolator package: field widths, action codes and defaults
// no dependencies; imported by media_clock_extrapolator, checker and bench

package mce_pkg;

	// field widths
	localparam int TIME_W   = 48;
	localparam int SPEED_W  = 24;
	localparam int ACTION_W = 3;

	// stream payload widths, whole bytes
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 56;

	// parameter defaults
	localparam int TIME_BITS_DEF       = 48;
	localparam int SPEED_FRAC_BITS_DEF = 16;

	// event actions, code 7 is handled as a query
	typedef enum logic [ACTION_W-1:0] {
		ACT_UPDATE_PTS = 3'd0,
		ACT_QUERY      = 3'd1,
		ACT_RESET      = 3'd2,
		ACT_RESET_TO   = 3'd3,
		ACT_PAUSE      = 3'd4,
		ACT_RESUME     = 3'd5,
		ACT_SET_SPEED  = 3'd6
	} action_t;

endpackage

// ===== sv/media_clock_extrapolator.sv =====
// media clock extrapolator: audio anchored media time with pause and speed control
// depends on mce_pkg
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tuser: action; tdata: now_us, pts_us, keep_paused, new_speed
//  m_axis   | out | tdata: media_time_us, anchored, is_paused
//
// one item per clock unless m_axis stalls; input register, then result register
// the clock state is updated in the cycle an item leaves the input register, so the
// next item sees it at once; the loop through the 48x24 multiply-add sets the clock
// arst_n clears the clock state (unanchored, running, speed 1.0) and both valid flags
// a stalled result holds in the result register and the next item waits in the input
// register; input is taken while the input register is empty or its item can move on

module media_clock_extrapolator
	import mce_pkg::*;
#(
	parameter int TIME_BITS       = TIME_BITS_DEF,
	parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// [47:0] now_us, [95:48] pts_us, [96] keep_paused, [120:97] new_speed
	input  logic [IN_DATA_W-1:0]    s_axis_tdata,
	// [2:0] action
	input  logic [ACTION_W-1:0]     s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// [47:0] media_time_us, [48] anchored, [49] is_paused
	output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

	localparam int PROD_W = TIME_W + SPEED_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic [SUM_W-1:0] TIME_MAX =
		(SUM_W'(1) << TIME_BITS) - SUM_W'(1);
	localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(1) << SPEED_FRAC_BITS;

	// input register
	logic                valid_s1;
	action_t             action_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [TIME_W-1:0]   pts_s1;
	logic                keep_s1;
	logic [SPEED_W-1:0]  speed_s1;

	// clock state
	logic [TIME_W-1:0]   anchor_pts_q;
	logic [TIME_W-1:0]   anchor_sys_q;
	logic                anchored_q;
	logic                paused_q;
	logic [SPEED_W-1:0]  speed_q;

	// result register
	logic                out_valid_q;
	logic [TIME_W-1:0]   out_time_q;
	logic                out_anchored_q;
	logic                out_paused_q;

	logic                in_take;
	logic                advance;

	logic [TIME_W-1:0]   elapsed;
	logic [55:0]         pp_lo;
	logic [39:0]         pp_hi;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   quot;
	logic [SUM_W-1:0]    ext_sum;
	logic [TIME_W-1:0]   run_time;
	logic [TIME_W-1:0]   hold_time;
	logic [TIME_W-1:0]   pts_sat;
	logic [TIME_W-1:0]   media_now;

	logic [TIME_W-1:0]   anchor_pts_d;
	logic [TIME_W-1:0]   anchor_sys_d;
	logic                anchored_d;
	logic                paused_d;
	logic [SPEED_W-1:0]  speed_d;
	logic [TIME_W-1:0]   result_time;

	// handshake
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action_t'(s_axis_tuser);
			now_s1    <= s_axis_tdata[47:0];
			pts_s1    <= s_axis_tdata[95:48];
			keep_s1   <= s_axis_tdata[96];
			speed_s1  <= s_axis_tdata[120:97];
		end
	end

	// elapsed time since the anchor, clamped at zero
	assign elapsed = (now_s1 > anchor_sys_q) ? (now_s1 - anchor_sys_q) : '0;

	// elapsed times speed as two partial products
	assign pp_lo = elapsed[31:0] * speed_q;
	assign pp_hi = elapsed[47:32] * speed_q;
	assign prod  = PROD_W'(pp_lo) + (PROD_W'(pp_hi) << 32);
	assign quot  = prod >> SPEED_FRAC_BITS;

	// add anchor pts and saturate at the time limit
	assign ext_sum   = SUM_W'(quot) + SUM_W'(anchor_pts_q);
	assign run_time  = (ext_sum > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : ext_sum[TIME_W-1:0];
	assign hold_time = (SUM_W'(anchor_pts_q) > TIME_MAX) ? TIME_MAX[TIME_W-1:0]
		: anchor_pts_q;
	assign pts_sat   = (SUM_W'(pts_s1) > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : pts_s1;

	// media time at now under the current state
	assign media_now = !anchored_q ? '0 : (paused_q ? hold_time : run_time);

	// next state and result
	always_comb begin
		anchor_pts_d = anchor_pts_q;
		anchor_sys_d = anchor_sys_q;
		anchored_d   = anchored_q;
		paused_d     = paused_q;
		speed_d      = speed_q;
		result_time  = media_now;
		case (action_s1)
			ACT_UPDATE_PTS: begin
				anchor_pts_d = pts_s1;
				anchor_sys_d = now_s1;
				anchored_d   = 1'b1;
				paused_d     = 1'b0;
				result_time  = pts_sat;
			end
			ACT_RESET: begin
				anchor_pts_d = '0;
				anchor_sys_d = '0;
				anchored_d   = 1'b0;
				paused_d     = 1'b0;
				result_time  = '0;
			end
			ACT_RESET_TO: begin
				anchor_pts_d = pts_s1;
				anchor_sys_d = now_s1;
				anchored_d   = 1'b1;
				if (!keep_s1) begin
					paused_d = 1'b0;
				end
				result_time  = pts_sat;
			end
			ACT_PAUSE: begin
				if (!paused_q) begin
					anchor_pts_d = media_now;
					anchor_sys_d = now_s1;
					paused_d     = 1'b1;
				end
			end
			ACT_RESUME: begin
				if (paused_q) begin
					anchor_sys_d = now_s1;
					paused_d     = 1'b0;
				end
			end
			ACT_SET_SPEED: begin
				anchor_pts_d = media_now;
				anchor_sys_d = now_s1;
				speed_d      = speed_s1;
			end
			default: begin
			end
		endcase
	end

	// clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_pts_q <= '0;
			anchor_sys_q <= '0;
			anchored_q   <= 1'b0;
			paused_q     <= 1'b0;
			speed_q      <= SPEED_ONE;
		end else if (advance) begin
			anchor_pts_q <= anchor_pts_d;
			anchor_sys_q <= anchor_sys_d;
			anchored_q   <= anchored_d;
			paused_q     <= paused_d;
			speed_q      <= speed_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_time_q     <= result_time;
			out_anchored_q <= anchored_d;
			out_paused_q   <= paused_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_paused_q, out_anchored_q, out_time_q};

	// an unanchored clock reports zero
	a_unanchored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_anchored_q |-> out_time_q == '0)
		else $error("unanchored clock reported nonzero media time");

	// reset clears both flags
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_RESET |=> !anchored_q && !paused_q)
		else $error("reset action left a flag set");

	// speed only changes on set_speed
	a_speed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && action_s1 == ACT_SET_SPEED) |=> $stable(speed_q))
		else $error("speed changed without set_speed");

	// pause always leaves the clock paused
	a_pause_sets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_PAUSE |=> paused_q)
		else $error("pause did not freeze the clock");

	// state only moves when an item moves into the result register
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(anchor_pts_q) && $stable(anchor_sys_q))
		else $error("anchor changed with no item in flight");

endmodule

// ===== sim/media_time_checker.sv =====
`timescale 1ns / 100ps
// event and result watcher for media_clock_extrapolator: predicts and compares each result
// depends on mce_pkg; instantiated by tb_media_clock_extrapolator beside the block

module media_time_checker
	import mce_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ev_valid,
	input  logic                  ev_ready,
	// [47:0] now_us, [95:48] pts_us, [96] keep_paused, [120:97] new_speed
	input  logic [IN_DATA_W-1:0]  ev_data,
	// [2:0] action
	input  logic [ACTION_W-1:0]   ev_user,
	input  logic                  res_valid,
	input  logic                  res_ready,
	// [47:0] media_time_us, [48] anchored, [49] is_paused
	input  logic [OUT_DATA_W-1:0] res_data,
	output int                    errors,
	output int                    pending
);

	// saturation point of the media time, 2^TIME_BITS - 1 with the default width
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// members from the top bit down, matching the result item layout
	typedef struct packed {
		logic              is_paused;
		logic              anchored;
		logic [TIME_W-1:0] media_time_us;
	} media_result_t;

	// clock state as the block should hold it
	logic [TIME_W-1:0]  anchor_pts;
	logic [TIME_W-1:0]  anchor_sys;
	logic               clk_anchored;
	logic               clk_paused;
	logic [SPEED_W-1:0] speed;

	media_result_t expected_media[$];
	media_result_t want;
	media_result_t got;

	// media time at a given system time under the current anchor and speed
	function automatic logic [TIME_W-1:0] media_time_at(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0]         elapsed;
		logic [TIME_W+SPEED_W-1:0] product;
		logic [TIME_W+SPEED_W:0]   sum;
		if (!clk_anchored)
			return '0;
		if (clk_paused)
			return anchor_pts;
		elapsed = (now > anchor_sys) ? now - anchor_sys : '0;
		product = elapsed * speed;
		sum = (product >> SPEED_FRAC_BITS_DEF) + anchor_pts;
		return (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// apply one event to the clock state and return the result it should produce
	function automatic media_result_t advance_clock(input logic [ACTION_W-1:0] act,
			input logic [IN_DATA_W-1:0] payload);
		logic [TIME_W-1:0]  now;
		logic [TIME_W-1:0]  pts;
		logic               keep;
		logic [SPEED_W-1:0] new_speed;
		media_result_t      res;
		now       = payload[47:0];
		pts       = payload[95:48];
		keep      = payload[96];
		new_speed = payload[120:97];
		case (act)
			ACT_UPDATE_PTS: begin
				anchor_pts   = pts;
				anchor_sys   = now;
				clk_paused   = 1'b0;
				clk_anchored = 1'b1;
			end
			ACT_RESET: begin
				anchor_pts   = '0;
				anchor_sys   = '0;
				clk_anchored = 1'b0;
				clk_paused   = 1'b0;
			end
			ACT_RESET_TO: begin
				anchor_pts   = pts;
				anchor_sys   = now;
				clk_anchored = 1'b1;
				if (!keep)
					clk_paused = 1'b0;
			end
			ACT_PAUSE: begin
				if (!clk_paused) begin
					anchor_pts = media_time_at(now);
					anchor_sys = now;
					clk_paused = 1'b1;
				end
			end
			ACT_RESUME: begin
				if (clk_paused) begin
					anchor_sys = now;
					clk_paused = 1'b0;
				end
			end
			ACT_SET_SPEED: begin
				// fold at the old speed so the media time does not jump
				anchor_pts = media_time_at(now);
				anchor_sys = now;
				speed      = new_speed;
			end
			// query and the unused code leave the state alone
			default: ;
		endcase
		res.media_time_us = media_time_at(now);
		res.anchored      = clk_anchored;
		res.is_paused     = clk_paused;
		return res;
	endfunction

	// compare results against the oldest expectation, then queue the new event's result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_pts   = '0;
			anchor_sys   = '0;
			clk_anchored = 1'b0;
			clk_paused   = 1'b0;
			speed        = SPEED_W'(1) << SPEED_FRAC_BITS_DEF;
			expected_media.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (res_valid && res_ready) begin
				got = res_data[TIME_W+1:0];
				if (expected_media.size() == 0) begin
					$error("result with no event outstanding: media_time_us %0h",
						got.media_time_us);
					errors++;
				end else begin
					want = expected_media.pop_front();
					if (got.media_time_us !== want.media_time_us) begin
						$error("media_time_us expected %0h actual %0h",
							want.media_time_us, got.media_time_us);
						errors++;
					end
					if (got.anchored !== want.anchored) begin
						$error("anchored expected %0b actual %0b", want.anchored, got.anchored);
						errors++;
					end
					if (got.is_paused !== want.is_paused) begin
						$error("is_paused expected %0b actual %0b", want.is_paused, got.is_paused);
						errors++;
					end
				end
			end
			if (ev_valid && ev_ready)
				expected_media.push_back(advance_clock(ev_user, ev_data));
			pending = expected_media.size();
		end
	end

endmodule

// ===== sim/tb_media_clock_extrapolator.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for media_clock_extrapolator: directed then random clock events
// depends on mce_pkg, media_clock_extrapolator and media_time_checker

module tb_media_clock_extrapolator;
	import mce_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
	localparam logic [SPEED_W-1:0]  SPEED_ONE  = SPEED_W'(1) << SPEED_FRAC_BITS_DEF;
	localparam logic [TIME_W-1:0]   T_MAX      = '1;
	localparam int N_RANDOM    = 1425;
	localparam int QUIET_TAIL  = 150;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AFTER  = 400;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [ACTION_W-1:0]   s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int errors;
	int pending;
	int sent = 0;
	bit quiet = 1'b0;
	bit hold_done = 1'b0;

	media_clock_extrapolator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	media_time_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (s_axis_tvalid),
		.ev_ready  (s_axis_tready),
		.ev_data   (s_axis_tdata),
		.ev_user   (s_axis_tuser),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (m_axis_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// offer one event, with an occasional gap ahead of it, and wait until it is taken
	task automatic send_event(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] pts, input logic keep, input logic [SPEED_W-1:0] spd);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {7'b0, spd, keep, pts, now};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// result side: one long hold-off to fill the block, random stalls otherwise
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && sent >= HOLD_AFTER) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// event side: directed corners, then a random timeline
	initial begin
		logic [TIME_W-1:0]   timeline;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   pts;
		logic [SPEED_W-1:0]  spd;
		logic [ACTION_W-1:0] act;
		int pick;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_QUERY;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unanchored clock, pause and speed change before any pts
		send_event(ACT_QUERY,      48'd100,  48'd0, 1'b0, '0);
		send_event(ACT_PAUSE,      48'd200,  48'd0, 1'b0, '0);
		send_event(ACT_SET_SPEED,  48'd300,  48'd0, 1'b0, SPEED_ONE);
		send_event(ACT_RESUME,     48'd400,  48'd0, 1'b0, '0);
		// anchor, run forward and query before the anchor time
		send_event(ACT_UPDATE_PTS, 48'd1000, 48'd5000, 1'b0, '0);
		send_event(ACT_QUERY,      48'd3000, 48'd0, 1'b0, '0);
		send_event(ACT_QUERY,      48'd500,  48'd0, 1'b0, '0);
		// pause twice, query frozen, change speed while paused, resume twice
		send_event(ACT_PAUSE,      48'd4000,  48'd0, 1'b0, '0);
		send_event(ACT_PAUSE,      48'd9000,  48'd0, 1'b0, '0);
		send_event(ACT_QUERY,      48'd20000, 48'd0, 1'b0, '0);
		send_event(ACT_SET_SPEED,  48'd21000, 48'd0, 1'b0, SPEED_ONE << 1);
		send_event(ACT_RESUME,     48'd30000, 48'd0, 1'b0, '0);
		send_event(ACT_RESUME,     48'd30005, 48'd0, 1'b0, '0);
		send_event(ACT_QUERY,      48'd30010, 48'd0, 1'b0, '0);
		// zero speed holds the media time
		send_event(ACT_SET_SPEED,  48'd31000, 48'd0, 1'b0, '0);
		send_event(ACT_QUERY,      48'd99999, 48'd0, 1'b0, '0);
		// largest speed and latest time: saturation, then a saturated fold
		send_event(ACT_SET_SPEED,  48'd40000, 48'd0, 1'b0, '1);
		send_event(ACT_QUERY,      T_MAX,     48'd0, 1'b0, '0);
		send_event(ACT_PAUSE,      T_MAX,     48'd0, 1'b0, '0);
		// re-anchor keeping the pause, then clearing it
		send_event(ACT_RESET_TO,   48'd0,     T_MAX, 1'b1, '0);
		send_event(ACT_RESET_TO,   48'd0,     48'd0, 1'b0, '0);
		// pts near the top plus fast elapsed time overflows
		send_event(ACT_UPDATE_PTS, 48'd10,    T_MAX - 48'hFF, 1'b0, '0);
		send_event(ACT_QUERY,      48'd100000, 48'd0, 1'b0, '0);
		send_event(ACT_UNUSED,     48'd1000,  48'd0, 1'b0, '0);
		send_event(ACT_RESET,      48'd5,     48'd0, 1'b0, '0);
		send_event(ACT_QUERY,      T_MAX,     48'd0, 1'b0, '0);
		send_event(ACT_SET_SPEED,  48'd0,     48'd0, 1'b0, SPEED_ONE);

		// random events along a mostly forward running system time
		timeline = 48'd1000000;
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= N_RANDOM - QUIET_TAIL);

			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				timeline = rand48();
				now = timeline;
			end else if (pick < 5) begin
				timeline = T_MAX - $urandom_range(0, 1000000);
				now = timeline;
			end else if (pick < 8) begin
				now = rand48();
			end else if (pick < 14) begin
				now = timeline - $urandom_range(1, 100000);
			end else begin
				timeline = timeline + $urandom_range(0, 40000);
				now = timeline;
			end

			pick = $urandom_range(0, 99);
			if (pick < 60)
				pts = now + $urandom_range(0, 1000000);
			else if (pick < 75)
				pts = rand48();
			else if (pick < 85)
				pts = T_MAX - $urandom_range(0, 5000);
			else
				pts = TIME_W'($urandom_range(0, 1000));

			pick = $urandom_range(0, 99);
			if (pick < 45)
				spd = SPEED_W'(SPEED_ONE + $urandom_range(0, 8192) - 4096);
			else if (pick < 60)
				spd = SPEED_W'($urandom_range(0, 255));
			else if (pick < 80)
				spd = SPEED_W'($urandom);
			else if (pick < 90)
				spd = '0;
			else
				spd = '1;

			pick = $urandom_range(0, 99);
			if (pick < 18)
				act = ACT_UPDATE_PTS;
			else if (pick < 42)
				act = ACT_QUERY;
			else if (pick < 46)
				act = ACT_RESET;
			else if (pick < 56)
				act = ACT_RESET_TO;
			else if (pick < 68)
				act = ACT_PAUSE;
			else if (pick < 80)
				act = ACT_RESUME;
			else if (pick < 95)
				act = ACT_SET_SPEED;
			else
				act = ACT_UNUSED;

			send_event(act, now, pts, 1'($urandom_range(0, 1)), spd);
		end

		// drain and settle
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
